@@ src/accumulator_alu_with_flags_unit_macros.svh @@
// Assertion macros for the accumulator ALU unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define AAF_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define AAF_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`else

`define AAF_ASSERT_IMP(lbl, cond, prop, msg)

`define AAF_ASSERT_NXT(lbl, cond, prop, msg)

`endif

`endif

@@ src/aaf_pkg.sv @@
`default_nettype none

package aaf_pkg;

  localparam int RF_DEPTH = 7;
  localparam int RF_AW    = 3;

  // Register file slots
  localparam logic [RF_AW-1:0] SLOT_H = 3'd4;
  localparam logic [RF_AW-1:0] SLOT_L = 3'd5;
  localparam logic [RF_AW-1:0] SLOT_A = 3'd6;

  // Item kinds
  localparam logic OP_EXEC  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register index codes on a write
  localparam logic [2:0] REG_IDX_MEM = 3'd6;
  localparam logic [2:0] REG_IDX_A   = 3'd7;

  // Opcode fields
  localparam logic [1:0] X_REG = 2'd2;
  localparam logic [1:0] X_IMM = 2'd3;
  localparam logic [2:0] Z_MEM = 3'd6;
  localparam logic [2:0] Z_A   = 3'd7;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_op_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] res;
    flags_t     flags;
  } alu_res_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [7:0]       data;
  } rf_wr_t;

endpackage

`default_nettype wire

@@ src/aaf_rf.sv @@
`default_nettype none

module aaf_rf (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [aaf_pkg::RF_AW-1:0] rd_addr,
  output logic      [7:0]                rd_data,
  input  wire aaf_pkg::rf_wr_t           wr
);
  import aaf_pkg::*;

  logic [7:0]          mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld_r;
  logic [7:0]          rd_q_r;
  logic                rd_vld_r;
  logic                byp_hit_r;
  logic [7:0]          byp_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        byp_hit_r <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : (rd_vld_r ? rd_q_r : 8'd0);

endmodule

`default_nettype wire

@@ src/aaf_alu.sv @@
`default_nettype none

module aaf_alu (
  input  wire aaf_pkg::alu_op_t  op,
  input  wire logic [7:0]        a,
  input  wire logic [7:0]        v,
  input  wire logic              cin,
  output aaf_pkg::alu_res_t      res
);
  import aaf_pkg::*;

  logic       c;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;

  always_comb begin
    c    = ((op == ALU_ADC) || (op == ALU_SBC)) ? cin : 1'b0;
    sum9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
    sum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
    dif9 = {1'b0, a} - {1'b0, v} - {8'd0, c};
    dif5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};

    res = '0;
    unique case (op)
      ALU_ADD, ALU_ADC: begin
        res.res     = sum9[7:0];
        res.flags.h = sum5[4];
        res.flags.c = sum9[8];
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        res.res     = dif9[7:0];
        res.flags.n = 1'b1;
        res.flags.h = dif5[4];
        res.flags.c = dif9[8];
      end
      ALU_AND: begin
        res.res     = a & v;
        res.flags.h = 1'b1;
      end
      ALU_XOR: begin
        res.res = a ^ v;
      end
      ALU_OR: begin
        res.res = a | v;
      end
    endcase
    res.flags.z = (res.res == 8'd0);
  end

endmodule

`default_nettype wire

@@ src/accumulator_alu_with_flags_unit.sv @@
`default_nettype none
// Accumulator ALU with flags: seven 8-bit registers (B, C, D, E, H, L, A) and
// four flags. Each input transfer is either a register write or an execute of
// one opcode byte; register-group (0x80..0xBF) and immediate (x=3, z=6) ALU
// opcodes run ADD/ADC/SUB/SBC/AND/XOR/OR/CP, everything else reports
// executed = 0 and changes nothing. Every input transfer yields exactly one
// output transfer showing A, the flags and H:L after the item. Throughput is
// one item per cycle while the output is not stalled; each item passes through
// stage 1 and then the output register. Input is stalled while in reset. The
// register file sits in a 7-entry synchronous memory read at input transfer
// time; the second stage modifies and writes back, and a write landing on the
// same edge as a later read is forwarded. A, H, L and the flags are also held
// in flops for the result. The rate is set by the read-modify-write of the
// accumulator in the second stage. No clearing pass is needed after reset:
// per-entry valid bits make unwritten entries read as zero. The output register
// lets a new item enter while a result waits.

`include "accumulator_alu_with_flags_unit_macros.svh"

module accumulator_alu_with_flags_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_opcode,
  input  wire logic [7:0]  in_extra_byte,
  input  wire logic [2:0]  in_reg_index,
  input  wire logic [7:0]  in_write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_acc,
  output logic             out_zero_flag,
  output logic             out_subtract_flag,
  output logic             out_half_flag,
  output logic             out_carry_out_flag,
  output logic [15:0]      out_hl_pair,
  output logic             out_executed
);
  import aaf_pkg::*;

  // Second stage
  logic       s1_vld_r;
  logic       s1_op_r;
  logic [7:0] s1_opcode_r;
  logic [7:0] s1_extra_r;
  logic [2:0] s1_ridx_r;
  logic [7:0] s1_wval_r;

  // Architectural copies for the result
  logic [7:0] a_r, a_nxt;
  logic [7:0] h_r, h_nxt;
  logic [7:0] l_r, l_nxt;
  flags_t     flags_r, flags_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_acc_r;
  flags_t      out_flags_r;
  logic [15:0] out_hl_r;
  logic        out_exec_r;

  logic       accept;
  logic       adv;
  logic       rd_en;
  logic [7:0] rd_data;
  rf_wr_t     wr;

  logic [1:0] x;
  logic [2:0] z;
  alu_op_t    alu_op;
  logic       is_alu;
  logic       is_wr;
  logic [2:0] wr_slot;
  logic [7:0] operand;
  alu_res_t   alu_out;

  // Handshake: stage 1 drains when the output register is free or being taken;
  // hold the input off while in reset
  assign adv      = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_vld_r && !adv);
  assign accept   = in_valid && !in_stall;

  // Issue the operand read at input transfer for register operands B..L
  assign rd_en = accept && (in_op == OP_EXEC) && (in_opcode[2:0] < Z_MEM);

  aaf_rf u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_opcode[2:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Decode the item held in stage 1
  assign x      = s1_opcode_r[7:6];
  assign z      = s1_opcode_r[2:0];
  assign alu_op = alu_op_t'(s1_opcode_r[5:3]);
  assign is_alu = (s1_op_r == OP_EXEC) && ((x == X_REG) || ((x == X_IMM) && (z == Z_MEM)));
  assign is_wr  = (s1_op_r == OP_WRITE) && (s1_ridx_r != REG_IDX_MEM);
  assign wr_slot = (s1_ridx_r == REG_IDX_A) ? SLOT_A : s1_ridx_r;

  always_comb begin
    if ((x == X_IMM) || (z == Z_MEM)) begin
      operand = s1_extra_r;
    end else if (z == Z_A) begin
      operand = a_r;
    end else begin
      operand = rd_data;
    end
  end

  aaf_alu u_alu (
    .op  (alu_op),
    .a   (a_r),
    .v   (operand),
    .cin (flags_r.c),
    .res (alu_out)
  );

  // Modify and write back
  always_comb begin
    a_nxt     = a_r;
    h_nxt     = h_r;
    l_nxt     = l_r;
    flags_nxt = flags_r;
    wr.en     = 1'b0;
    wr.addr   = wr_slot;
    wr.data   = s1_wval_r;
    if (is_wr) begin
      wr.en = adv;
      if (wr_slot == SLOT_A) begin
        a_nxt = s1_wval_r;
      end
      if (wr_slot == SLOT_H) begin
        h_nxt = s1_wval_r;
      end
      if (wr_slot == SLOT_L) begin
        l_nxt = s1_wval_r;
      end
    end else if (is_alu) begin
      flags_nxt = alu_out.flags;
      // CP only sets flags
      if (alu_op != ALU_CP) begin
        a_nxt   = alu_out.res;
        wr.en   = adv;
        wr.addr = SLOT_A;
        wr.data = alu_out.res;
      end
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      a_r         <= 8'd0;
      h_r         <= 8'd0;
      l_r         <= 8'd0;
      flags_r     <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        a_r         <= a_nxt;
        h_r         <= h_nxt;
        l_r         <= l_nxt;
        flags_r     <= flags_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold stage 1 and the output register until they move on
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_op;
      s1_opcode_r <= in_opcode;
      s1_extra_r  <= in_extra_byte;
      s1_ridx_r   <= in_reg_index;
      s1_wval_r   <= in_write_value;
    end
    if (adv) begin
      out_acc_r   <= a_nxt;
      out_flags_r <= flags_nxt;
      out_hl_r    <= {h_nxt, l_nxt};
      out_exec_r  <= is_alu || is_wr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_acc            = out_acc_r;
  assign out_zero_flag      = out_flags_r.z;
  assign out_subtract_flag  = out_flags_r.n;
  assign out_half_flag      = out_flags_r.h;
  assign out_carry_out_flag = out_flags_r.c;
  assign out_hl_pair        = out_hl_r;
  assign out_executed       = out_exec_r;

  // An item that does nothing leaves A and the flags alone
  `AAF_ASSERT_NXT(a_noexec_hold, adv && !is_alu && !is_wr, $stable(a_r) && $stable(flags_r), "non-executed item changed state")
  // Compare keeps A and sets the subtract flag
  `AAF_ASSERT_NXT(a_cp_keeps_acc, adv && is_alu && (alu_op == ALU_CP), $stable(a_r) && flags_r.n, "compare altered accumulator")
  // The accumulator copy tracks every write to slot A
  `AAF_ASSERT_NXT(a_acc_coherent, wr.en && (wr.addr == SLOT_A), a_r == $past(wr.data), "accumulator copy out of step with register file")
  // Stage 1 stalls input only while it holds an item
  `AAF_ASSERT_IMP(a_stall_occupied, in_stall, s1_vld_r && out_valid_r, "input stalled with free pipeline")

endmodule

`default_nettype wire

@@ tb/accumulator_alu_with_flags_unit_tb.sv @@
`default_nettype none

module accumulator_alu_with_flags_unit_tb;
  import aaf_pkg::*;

  localparam int    RANDOM_ITEMS = 1125;  // random items after the directed part
  localparam int    STALL_LIMIT  = 2000;  // cycles without any transfer
  localparam int    DRAIN_CYCLES = 8;     // extra wait for stray results
  localparam int    REPORT_MAX   = 10;
  localparam [7:0]  CB_PREFIX    = 8'hCB;
  localparam [7:0]  NOP_OPCODE   = 8'h00;
  localparam [7:0]  LD_A_A       = 8'h7F;
  localparam [7:0]  RST_38       = 8'hFF;
  localparam [2:0]  REG_B        = 3'd0;
  localparam [2:0]  REG_C        = 3'd1;
  localparam [2:0]  REG_D        = 3'd2;
  localparam [2:0]  REG_E        = 3'd3;
  localparam [2:0]  REG_H        = 3'd4;
  localparam [2:0]  REG_L        = 3'd5;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [7:0]  acc;
    flags_t      fl;
    logic [15:0] hl;
    logic        exe;
  } cpu_view_t;

  // Tracks the register file and flags, and holds the results still owed.
  class acc_flag_scoreboard;
    logic [7:0] regs [RF_DEPTH];
    flags_t     flg;
    cpu_view_t  owed_results [$];
    int         mismatches;
    int         checked;
    int         accepted;
    int         executed;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      flg = '0;
      mismatches = 0;
      checked = 0;
      accepted = 0;
      executed = 0;
    endfunction

    // Run one accumulator operation against operand v.
    function void apply_alu(alu_op_t aop, logic [7:0] v);
      logic [7:0] a;
      logic       c;
      logic [8:0] sum;
      logic [4:0] nib;
      logic [7:0] res;
      flags_t     f;
      a = regs[SLOT_A];
      f = '0;
      c = 1'b0;
      case (aop)
        ALU_ADD, ALU_ADC: begin
          if (aop == ALU_ADC) c = flg.c;
          sum = {1'b0, a} + {1'b0, v} + 9'(c);
          nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + 5'(c);
          f.h = nib[4];
          f.c = sum[8];
          res = sum[7:0];
        end
        ALU_SUB, ALU_SBC, ALU_CP: begin
          if (aop == ALU_SBC) c = flg.c;
          f.n = 1'b1;
          f.h = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + 5'(c));
          f.c = {1'b0, a} < ({1'b0, v} + 9'(c));
          res = a - v - 8'(c);
        end
        ALU_AND: begin
          res = a & v;
          f.h = 1'b1;
        end
        ALU_XOR: res = a ^ v;
        default: res = a | v;
      endcase
      f.z = (res == 8'h00);
      flg = f;
      if (aop != ALU_CP) regs[SLOT_A] = res;
    endfunction

    function void note_transfer(logic op, logic [7:0] opcode, logic [7:0] extra,
                                logic [2:0] ridx, logic [7:0] wval);
      logic      done;
      logic [7:0] v;
      cpu_view_t r;
      done = 1'b0;
      accepted++;
      if (op == OP_WRITE) begin
        if (ridx != REG_IDX_MEM) begin
          regs[(ridx == REG_IDX_A) ? SLOT_A : ridx] = wval;
          done = 1'b1;
        end
      end else if (opcode[7:6] == X_REG) begin
        if (opcode[2:0] == Z_MEM) v = extra;
        else if (opcode[2:0] == Z_A) v = regs[SLOT_A];
        else v = regs[opcode[2:0]];
        apply_alu(alu_op_t'(opcode[5:3]), v);
        done = 1'b1;
      end else if (opcode[7:6] == X_IMM && opcode[2:0] == Z_MEM) begin
        apply_alu(alu_op_t'(opcode[5:3]), extra);
        done = 1'b1;
      end
      if (done) executed++;
      r.acc = regs[SLOT_A];
      r.fl  = flg;
      r.hl  = {regs[SLOT_H], regs[SLOT_L]};
      r.exe = done;
      owed_results.push_back(r);
    endfunction

    function void check_transfer(cpu_view_t got);
      cpu_view_t want;
      checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: acc=%02h znhc=%b hl=%04h exe=%b",
                   got.acc, got.fl, got.hl, got.exe);
        return;
      end
      want = owed_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d differs: expected acc=%02h znhc=%b hl=%04h exe=%b,",
                   checked, want.acc, want.fl, want.hl, want.exe,
                   " got acc=%02h znhc=%b hl=%04h exe=%b",
                   got.acc, got.fl, got.hl, got.exe);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [7:0]  in_opcode = 8'h00;
  logic [7:0]  in_extra_byte = 8'h00;
  logic [2:0]  in_reg_index = 3'd0;
  logic [7:0]  in_write_value = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_acc;
  logic        out_zero_flag;
  logic        out_subtract_flag;
  logic        out_half_flag;
  logic        out_carry_out_flag;
  logic [15:0] out_hl_pair;
  logic        out_executed;

  bit          calm = 1'b0;   // set while neither side may idle
  int          idle_cycles = 0;
  acc_flag_scoreboard sb = new();

  accumulator_alu_with_flags_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_opcode          (in_opcode),
    .in_extra_byte      (in_extra_byte),
    .in_reg_index       (in_reg_index),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_acc            (out_acc),
    .out_zero_flag      (out_zero_flag),
    .out_subtract_flag  (out_subtract_flag),
    .out_half_flag      (out_half_flag),
    .out_carry_out_flag (out_carry_out_flag),
    .out_hl_pair        (out_hl_pair),
    .out_executed       (out_executed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall about one cycle in ten, never during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // Observe both channels at the edge, before any driver update lands.
  // Check results first: an output transfer on this edge always belongs to
  // an input transfer from an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_transfer({out_acc, out_zero_flag, out_subtract_flag, out_half_flag,
                           out_carry_out_flag, out_hl_pair, out_executed});
      if (in_valid && !in_stall)
        sb.note_transfer(in_op, in_opcode, in_extra_byte, in_reg_index, in_write_value);
    end
  end

  // Watchdog: give up once neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Bias byte values towards the carry and half-carry boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h0F;
      5:       return 8'hF0;
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Called at a rising
  // edge; returns at the edge of the transfer. An optional gap goes first, with
  // junk on the payload while valid is low.
  task automatic send_item(input logic op, input logic [7:0] opcode,
                           input logic [7:0] extra, input logic [2:0] ridx,
                           input logic [7:0] wval);
    if (!calm && $urandom_range(99) < 4) begin
      in_valid       <= 1'b0;
      in_op          <= 1'($urandom);
      in_opcode      <= 8'($urandom);
      in_extra_byte  <= 8'($urandom);
      in_reg_index   <= 3'($urandom);
      in_write_value <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_opcode      <= opcode;
    in_extra_byte  <= extra;
    in_reg_index   <= ridx;
    in_write_value <= wval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Register load; the unused execute fields carry random junk.
  task automatic send_write(input logic [2:0] ridx, input logic [7:0] wval);
    send_item(OP_WRITE, 8'($urandom), 8'($urandom), ridx, wval);
  endtask

  // Opcode execute; the unused write fields carry random junk.
  task automatic send_exec(input logic [7:0] opcode, input logic [7:0] extra);
    send_item(OP_EXEC, opcode, extra, 3'($urandom), 8'($urandom));
  endtask

  initial begin
    int         sent;
    int         kind;
    logic [2:0] ridx;
    logic [7:0] opcode;
    alu_op_t    aop;

    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: load every register, including the ignored index six,
    // then walk each operation through its corner cases.
    send_write(REG_B, 8'hFF);
    send_write(REG_C, 8'h01);
    send_write(REG_D, 8'h80);
    send_write(REG_E, 8'h7F);
    send_write(REG_H, 8'h12);
    send_write(REG_L, 8'h34);
    send_write(REG_IDX_MEM, 8'hAA);
    send_write(REG_IDX_A, 8'hFF);
    // 0xFF + 1 wraps to zero: sets zero, half-carry and carry together.
    send_exec({X_REG, ALU_ADD, REG_C}, 8'h00);
    // Carry-in alone pushes the low nibble over: half-carry from carry-in.
    send_write(REG_IDX_A, 8'h0F);
    send_exec({X_IMM, ALU_ADC, Z_MEM}, 8'h00);
    // Borrow out of the byte without a nibble borrow.
    send_exec({X_REG, ALU_SUB, REG_D}, 8'h00);
    // Memory operand with the old carry folded into both borrows.
    send_exec({X_REG, ALU_SBC, Z_MEM}, 8'hFF);
    send_exec({X_REG, ALU_AND, REG_E}, 8'h00);
    // A xor A clears the accumulator; A as operand.
    send_exec({X_REG, ALU_XOR, Z_A}, 8'h00);
    send_exec({X_IMM, ALU_OR, Z_MEM}, 8'h80);
    // Compare keeps A whatever the flags say.
    send_exec({X_REG, ALU_CP, REG_B}, 8'h00);
    send_exec({X_IMM, ALU_CP, Z_MEM}, 8'h80);
    // Opcodes outside both ALU groups, the CB prefix among them.
    send_exec(CB_PREFIX, 8'h55);
    send_exec(NOP_OPCODE, 8'hFF);
    send_exec(LD_A_A, 8'h00);
    send_exec(RST_38, 8'h00);
    send_exec({X_IMM, ALU_SUB, Z_MEM}, 8'h01);
    send_exec({X_REG, ALU_ADD, REG_H}, 8'h00);
    send_exec({X_REG, ALU_ADC, REG_L}, 8'h00);

    // Random part: mostly ALU work on boundary-heavy data, with register loads
    // to keep the operands moving and some foreign opcodes as noise. Hold a
    // calm stretch in the middle.
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 400 && sent < 650);
      kind = $urandom_range(99);
      if (kind < 30) begin
        ridx = 3'($urandom_range(7));
        send_write(ridx, pick_byte());
      end else if (kind < 85) begin
        aop = alu_op_t'($urandom_range(7));
        if ($urandom_range(3) == 0) opcode = {X_IMM, aop, Z_MEM};
        else opcode = {X_REG, aop, 3'($urandom_range(7))};
        send_exec(opcode, pick_byte());
      end else begin
        opcode = ($urandom_range(3) == 0) ? CB_PREFIX : 8'($urandom);
        send_exec(opcode, pick_byte());
      end
      sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items transferred, %0d of them executed; %0d results checked",
             sb.accepted, sb.executed, sb.checked);
    $display("all eight ALU operations over both operand groups, loads of every register");
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding",
               sb.mismatches, sb.owed_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/aaf_pkg.sv
src/aaf_rf.sv
src/aaf_alu.sv
src/accumulator_alu_with_flags_unit.sv
tb/accumulator_alu_with_flags_unit_tb.sv
